/* design/rwb_pkg.sv */
// Reorder window buffer: shared widths, command and status codes, register
// indexes and the types passed between the configuration block and the core.
// No dependencies.
package rwb_pkg;

  localparam int DEPTH_DEF = 64;

  localparam int CMD_W     = 3;
  localparam int SEQ_W     = 32;
  localparam int REF_W     = 32;
  localparam int LEN_W     = 16;
  localparam int STAT_W    = 4;
  localparam int WS_W      = 7;
  localparam int START_W   = 31;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;

  localparam logic [WS_W-1:0]    WS_RESET    = 7'd64;
  localparam logic [START_W-1:0] START_RESET = '0;

  localparam logic REG_WINDOW_SIZE = 1'b0;
  localparam logic REG_START_SEQ   = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT  = 3'd0,
    CMD_DEQUEUE = 3'd1,
    CMD_DRAIN   = 3'd2,
    CMD_FIND    = 3'd3,
    CMD_CLEAR   = 3'd4,
    CMD_RESTART = 3'd5
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 4'd0,
    ST_FULL      = 4'd1,
    ST_BAD_LEN   = 4'd2,
    ST_SLOT_USED = 4'd3,
    ST_RANGE     = 4'd4,
    ST_FOUND     = 4'd5,
    ST_NOT_FOUND = 4'd6,
    ST_DEQUEUED  = 4'd7,
    ST_EMPTY     = 4'd8,
    ST_DONE      = 4'd9
  } status_t;

  typedef struct packed {
    logic [WS_W-1:0]    window_size;
    logic [START_W-1:0] start_seq;
  } cfg_regs_t;

  typedef struct packed {
    logic [REF_W-1:0] blk_ref;
    logic [LEN_W-1:0] blk_len;
  } slot_t;

endpackage

/* design/rwb_if.sv */
// Reorder window buffer: valid/ready channel interfaces for command
// transactions and result transactions. Depends on rwb_pkg.
interface rwb_in_if;
  import rwb_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        cmd;
  logic signed [SEQ_W-1:0] seq;
  logic [REF_W-1:0]        block_ref;
  logic [LEN_W-1:0]        block_length;
  logic                    overwrite;

  modport source (output valid, cmd, seq, block_ref, block_length, overwrite,
                  input ready);
  modport sink   (input valid, cmd, seq, block_ref, block_length, overwrite,
                  output ready);
endinterface

interface rwb_out_if;
  import rwb_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [STAT_W-1:0]       status;
  logic signed [SEQ_W-1:0] out_seq;
  logic [REF_W-1:0]        out_ref;
  logic [LEN_W-1:0]        out_length;
  logic signed [SEQ_W-1:0] confirm_seq;
  logic signed [SEQ_W-1:0] max_seq;
  logic                    last;

  modport source (output valid, status, out_seq, out_ref, out_length, confirm_seq,
                  max_seq, last, input ready);
  modport sink   (input valid, status, out_seq, out_ref, out_length, confirm_seq,
                  max_seq, last, output ready);
endinterface

/* design/reorder_window_buffer_top.sv */
// Reorder window buffer top level: APB-style register file plus the window core.
// Depends on rwb_pkg, rwb_if, rwb_cfg and rwb_core.
//
// Each command transaction is registered on acceptance; its result is loaded into
// the output register once that is free. Dequeue and drain first read the head
// slot from the payload memory, whose read data is registered, after which drain
// releases one block per cycle unless the output stalls, until it meets an empty
// slot or has released the active window size. A new command is accepted once the
// final result of the previous one is in the output register. Window size and
// start sequence take effect at reset and on restart; codes 6 and 7 are dropped.
module reorder_window_buffer_top #(
  parameter int DEPTH = rwb_pkg::DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  rwb_in_if.sink                      in_chan,
  rwb_out_if.source                   out_chan,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rwb_pkg::PADDR_W-1:0] paddr,
  input  logic [rwb_pkg::PDATA_W-1:0] pwdata,
  output logic [rwb_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  import rwb_pkg::*;

  cfg_regs_t cfg_regs;

  rwb_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg_regs)
  );

  rwb_core #(
    .DEPTH (DEPTH)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_i    (cfg_regs)
  );

endmodule

/* design/rwb_cfg.sv */
// Reorder window buffer: APB-style register file holding window_size and
// start_seq. Depends on rwb_pkg.
module rwb_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rwb_pkg::PADDR_W-1:0]   paddr,
  input  logic [rwb_pkg::PDATA_W-1:0]   pwdata,
  output logic [rwb_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  output rwb_pkg::cfg_regs_t            cfg_o
);
  import rwb_pkg::*;

  logic [WS_W-1:0]    window_size_r;
  logic [START_W-1:0] start_seq_r;
  logic               wr_en;
  logic               reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_size_r <= WS_RESET;
      start_seq_r   <= START_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_WINDOW_SIZE: window_size_r <= pwdata[WS_W-1:0];
        REG_START_SEQ:   start_seq_r   <= pwdata[START_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_WINDOW_SIZE: prdata = PDATA_W'(window_size_r);
      REG_START_SEQ:   prdata = PDATA_W'(start_seq_r);
      default:         prdata = '0;
    endcase
  end

  assign cfg_o.window_size = window_size_r;
  assign cfg_o.start_seq   = start_seq_r;

endmodule

/* design/rwb_core.sv */
// Reorder window buffer: command sequencer, slot valid bits, slot payload
// memory and result register. Depends on rwb_pkg and rwb_if.
module rwb_core #(
  parameter int DEPTH = rwb_pkg::DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  rwb_in_if.sink             in_chan,
  rwb_out_if.source          out_chan,
  input  rwb_pkg::cfg_regs_t cfg_i
);
  import rwb_pkg::*;

  localparam int SLOT_W = $clog2(DEPTH);
  localparam int SIZE_W = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_EXEC  = 3'b010,
    S_DRAIN = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic [CMD_W-1:0]  cmd_r;
  logic [SEQ_W-1:0]  seq_r;
  logic [REF_W-1:0]  ref_r;
  logic [LEN_W-1:0]  len_r;
  logic              ow_r;
  logic              in_rng_r;
  logic [SIZE_W-1:0] off_lo_r;
  logic              hi_upd_r;

  logic [DEPTH-1:0]  valid_r, valid_nxt;
  logic [SEQ_W-1:0]  expect_r, expect_nxt;
  logic [SEQ_W-1:0]  highest_r, highest_nxt;
  logic [SLOT_W-1:0] head_r, head_nxt;
  logic [SIZE_W-1:0] act_r, act_nxt;
  logic [SIZE_W-1:0] cnt_r, cnt_nxt;

  slot_t             mem [DEPTH];
  slot_t             rd_q;
  logic              mem_we, mem_re;
  logic [SLOT_W-1:0] mem_raddr;

  logic              out_valid_r;
  status_t           o_status_r, o_status;
  logic [SEQ_W-1:0]  o_seq_r, o_seq;
  logic [REF_W-1:0]  o_ref_r, o_ref;
  logic [LEN_W-1:0]  o_len_r, o_len;
  logic [SEQ_W-1:0]  o_confirm_r;
  logic [SEQ_W-1:0]  o_max_r;
  logic              o_last_r, o_last;
  logic              ld;

  logic              in_acc;
  logic              load_ok;
  logic [SEQ_W-1:0]  off;
  logic [SEQ_W-1:0]  dlt;
  logic [SIZE_W:0]   slot_sum;
  logic [SIZE_W:0]   slot_mod;
  logic [SLOT_W-1:0] slot_idx;
  logic [SLOT_W-1:0] head_inc;
  logic [SIZE_W-1:0] clamp_size;
  logic              more;

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign load_ok       = !out_valid_r || out_chan.ready;

  assign off = SEQ_W'(in_chan.seq) - expect_r;
  assign dlt = SEQ_W'(in_chan.seq) - highest_r;

  assign slot_sum = (SIZE_W+1)'(head_r) + (SIZE_W+1)'(off_lo_r);
  assign slot_mod = (slot_sum >= (SIZE_W+1)'(act_r)) ? slot_sum - (SIZE_W+1)'(act_r)
                                                       : slot_sum;
  assign slot_idx = slot_mod[SLOT_W-1:0];

  assign head_inc = ((SIZE_W'(head_r) + 1'b1) == act_r) ? '0 : head_r + 1'b1;

  always_comb begin
    priority if (cfg_i.window_size == '0) begin
      clamp_size = SIZE_W'(1);
    end else if (cfg_i.window_size > WS_W'(DEPTH)) begin
      clamp_size = SIZE_W'(DEPTH);
    end else begin
      clamp_size = SIZE_W'(cfg_i.window_size);
    end
  end

  always_comb begin
    state_nxt   = state_r;
    valid_nxt   = valid_r;
    expect_nxt  = expect_r;
    highest_nxt = highest_r;
    head_nxt    = head_r;
    act_nxt     = act_r;
    cnt_nxt     = cnt_r;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_raddr   = head_r;
    ld          = 1'b0;
    o_status    = ST_DONE;
    o_seq       = '0;
    o_ref       = '0;
    o_len       = '0;
    o_last      = 1'b1;
    more        = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_chan.cmd)
            CMD_INSERT, CMD_FIND, CMD_CLEAR, CMD_RESTART: state_nxt = S_EXEC;
            CMD_DEQUEUE, CMD_DRAIN: begin
              state_nxt = S_DRAIN;
              mem_re    = 1'b1;
              cnt_nxt   = '0;
            end
            default: ;
          endcase
        end
      end

      S_EXEC: begin
        if (load_ok) begin
          ld        = 1'b1;
          state_nxt = S_IDLE;
          unique case (cmd_r)
            CMD_INSERT: begin
              priority if (len_r == '0) begin
                o_status = ST_BAD_LEN;
              end else if (!in_rng_r) begin
                o_status = ST_RANGE;
              end else if (valid_r[slot_idx] && !ow_r) begin
                o_status = ST_SLOT_USED;
              end else begin
                mem_we              = 1'b1;
                valid_nxt[slot_idx] = 1'b1;
                if (hi_upd_r) begin
                  highest_nxt = seq_r;
                end
                o_status = (off_lo_r == act_r - 1'b1) ? ST_FULL : ST_OK;
              end
            end
            CMD_FIND: begin
              o_status = (in_rng_r && valid_r[slot_idx]) ? ST_FOUND : ST_NOT_FOUND;
            end
            CMD_CLEAR: begin
              valid_nxt = '0;
              o_status  = ST_DONE;
            end
            CMD_RESTART: begin
              valid_nxt   = '0;
              act_nxt     = clamp_size;
              expect_nxt  = SEQ_W'(cfg_i.start_seq);
              head_nxt    = '0;
              highest_nxt = SEQ_W'(cfg_i.start_seq) - 1'b1;
              o_status    = ST_DONE;
            end
            default: ld = 1'b0;
          endcase
        end
      end

      S_DRAIN: begin
        if (load_ok) begin
          ld = 1'b1;
          if (valid_r[head_r]) begin
            valid_nxt[head_r] = 1'b0;
            expect_nxt        = expect_r + 1'b1;
            head_nxt          = head_inc;
            cnt_nxt           = cnt_r + 1'b1;
            o_status          = ST_DEQUEUED;
            o_seq             = expect_r;
            o_ref             = rd_q.blk_ref;
            o_len             = rd_q.blk_len;
            more              = (cmd_r == CMD_DRAIN) && ((cnt_r + 1'b1) < act_r) &&
                                valid_r[head_inc];
            o_last            = !more;
            if (more) begin
              mem_re    = 1'b1;
              mem_raddr = head_inc;
            end else begin
              state_nxt = S_IDLE;
            end
          end else begin
            o_status  = ST_EMPTY;
            state_nxt = S_IDLE;
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[slot_idx] <= '{blk_ref: ref_r, blk_len: len_r};
    end
    if (mem_re) begin
      rd_q <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      expect_r    <= SEQ_W'(START_RESET);
      highest_r   <= SEQ_W'(START_RESET) - 1'b1;
      head_r      <= '0;
      act_r       <= SIZE_W'(DEPTH);
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      valid_r   <= valid_nxt;
      expect_r  <= expect_nxt;
      highest_r <= highest_nxt;
      head_r    <= head_nxt;
      act_r     <= act_nxt;
      cnt_r     <= cnt_nxt;
      if (ld) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r    <= in_chan.cmd;
      seq_r    <= SEQ_W'(in_chan.seq);
      ref_r    <= in_chan.block_ref;
      len_r    <= in_chan.block_length;
      ow_r     <= in_chan.overwrite;
      in_rng_r <= ((off >> SIZE_W) == '0) && (off[SIZE_W-1:0] < act_r);
      off_lo_r <= off[SIZE_W-1:0];
      hi_upd_r <= (dlt != '0) && !dlt[SEQ_W-1];
    end
    if (ld) begin
      o_status_r  <= o_status;
      o_seq_r     <= o_seq;
      o_ref_r     <= o_ref;
      o_len_r     <= o_len;
      o_confirm_r <= expect_nxt - 1'b1;
      o_max_r     <= highest_nxt;
      o_last_r    <= o_last;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.status      = o_status_r;
  assign out_chan.out_seq     = o_seq_r;
  assign out_chan.out_ref     = o_ref_r;
  assign out_chan.out_length  = o_len_r;
  assign out_chan.confirm_seq = o_confirm_r;
  assign out_chan.max_seq     = o_max_r;
  assign out_chan.last        = o_last_r;

  a_head_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    SIZE_W'(head_r) < act_r)
    else $error("head slot outside active window");

  a_insert_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |=> valid_r[$past(slot_idx)])
    else $error("stored slot not marked valid");

  a_release_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (ld && o_status == ST_DEQUEUED) |=> !valid_r[$past(head_r)])
    else $error("released slot still valid");

  a_last_ends_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (ld && o_last) |=> (state_r == S_IDLE))
    else $error("sequencer busy after final result");

endmodule

/* test/tb_reorder_window_buffer_top.sv */
// Testbench for reorder_window_buffer_top: directed table plus random command traffic,
// every result transaction checked against a behavioral window model.
// Depends on rwb_pkg, rwb_in_if / rwb_out_if and the reorder_window_buffer_top RTL.
module tb_reorder_window_buffer_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rwb_pkg::*;

  localparam int DEPTH = DEPTH_DEF;
  localparam int PER_PHASE = 48;
  localparam int NUM_SETTINGS = 7;
  localparam int LONG_HOLD = 150;
  localparam logic [CMD_W-1:0] CMD_RSVD6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_RSVD7 = 3'd7;

  typedef struct {
    logic [CMD_W-1:0] cmd;
    logic [SEQ_W-1:0] seq;
    logic [REF_W-1:0] bref;
    logic [LEN_W-1:0] blen;
    logic             ow;
  } window_cmd_t;

  typedef struct {
    logic [STAT_W-1:0] status;
    logic [SEQ_W-1:0]  rel_seq;
    logic [REF_W-1:0]  rel_ref;
    logic [LEN_W-1:0]  rel_len;
    logic [SEQ_W-1:0]  confirm;
    logic [SEQ_W-1:0]  top;
    logic              last;
  } window_result_t;

  typedef struct {
    bit          is_cfg;
    logic [31:0] ws_val;
    logic [31:0] start_val;
    window_cmd_t item;
    bit          typed;
    status_t     status;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic psel, penable, pwrite, pready;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata, prdata;

  rwb_in_if  cmd_chan ();
  rwb_out_if result_chan ();

  reorder_window_buffer_top #(.DEPTH(DEPTH)) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (cmd_chan),
    .out_chan (result_chan),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // window model state
  logic [WS_W-1:0]    cfg_window;
  logic [START_W-1:0] cfg_start;
  logic               slot_full [DEPTH];
  logic [REF_W-1:0]   slot_ref_m [DEPTH];
  logic [LEN_W-1:0]   slot_len_m [DEPTH];
  logic [SEQ_W-1:0]   next_seq;
  logic [SEQ_W-1:0]   top_seq;
  int unsigned        head;
  int unsigned        win;

  window_result_t awaited_results [$];
  stim_row_t      stim_table [$];

  bit calm;
  bit hold_out;
  int fail_count;
  int cmds_sent;
  int results_checked;
  int blocks_released;
  int full_hits;

  function automatic void window_restart();
    foreach (slot_full[i]) slot_full[i] = 1'b0;
    if (cfg_window == 0) win = 1;
    else if (cfg_window > DEPTH) win = DEPTH;
    else win = 32'(cfg_window);
    next_seq = {1'b0, cfg_start};
    head = 0;
    top_seq = next_seq - 1;
  endfunction

  function automatic void push_result(input status_t st, input logic [SEQ_W-1:0] s,
                                      input logic [REF_W-1:0] r, input logic [LEN_W-1:0] l,
                                      input logic lst);
    window_result_t e;
    e.status  = st;
    e.rel_seq = s;
    e.rel_ref = r;
    e.rel_len = l;
    e.confirm = next_seq - 1;
    e.top     = top_seq;
    e.last    = lst;
    awaited_results.insert(awaited_results.size(), e);
  endfunction

  function automatic bit window_release(output logic [SEQ_W-1:0] s,
                                        output logic [REF_W-1:0] r,
                                        output logic [LEN_W-1:0] l);
    int unsigned h;
    s = '0;
    r = '0;
    l = '0;
    h = head % win;
    if (!slot_full[h] || slot_len_m[h] == 0) return 1'b0;
    s = next_seq;
    r = slot_ref_m[h];
    l = slot_len_m[h];
    slot_full[h] = 1'b0;
    next_seq = next_seq + 1;
    head = (h + 1) % win;
    blocks_released++;
    return 1'b1;
  endfunction

  function automatic void apply_window_cmd(input window_cmd_t it);
    logic [SEQ_W-1:0] off, d, s;
    logic [REF_W-1:0] r;
    logic [LEN_W-1:0] l;
    int unsigned      slot, k;
    status_t          st;
    off = it.seq - next_seq;
    slot = (head + off) % win;
    case (it.cmd)
      CMD_INSERT: begin
        if (it.blen == 0) begin
          st = ST_BAD_LEN;
        end else if (off >= win) begin
          st = ST_RANGE;
        end else if (slot_full[slot] && !it.ow) begin
          st = ST_SLOT_USED;
        end else begin
          d = it.seq - top_seq;
          slot_full[slot] = 1'b1;
          slot_ref_m[slot] = it.bref;
          slot_len_m[slot] = it.blen;
          if (d != 0 && !d[SEQ_W-1]) top_seq = it.seq;
          if (off == win - 1) begin
            st = ST_FULL;
            full_hits++;
          end else begin
            st = ST_OK;
          end
        end
        push_result(st, '0, '0, '0, 1'b1);
      end
      CMD_DEQUEUE: begin
        if (window_release(s, r, l)) push_result(ST_DEQUEUED, s, r, l, 1'b1);
        else push_result(ST_EMPTY, '0, '0, '0, 1'b1);
      end
      CMD_DRAIN: begin
        k = 0;
        while (k < win && window_release(s, r, l)) begin
          push_result(ST_DEQUEUED, s, r, l, 1'b0);
          k++;
        end
        if (k == 0) push_result(ST_EMPTY, '0, '0, '0, 1'b1);
        else awaited_results[awaited_results.size()-1].last = 1'b1;
      end
      CMD_FIND: begin
        if (off < win && slot_full[slot]) push_result(ST_FOUND, '0, '0, '0, 1'b1);
        else push_result(ST_NOT_FOUND, '0, '0, '0, 1'b1);
      end
      CMD_CLEAR: begin
        foreach (slot_full[i]) slot_full[i] = 1'b0;
        push_result(ST_DONE, '0, '0, '0, 1'b1);
      end
      CMD_RESTART: begin
        window_restart();
        push_result(ST_DONE, '0, '0, '0, 1'b1);
      end
      default: ;
    endcase
  endfunction

  function automatic window_cmd_t gen_item();
    window_cmd_t it;
    int unsigned p;
    p = $urandom_range(0, 99);
    it.seq  = $urandom;
    it.bref = $urandom;
    it.blen = LEN_W'($urandom_range(1, 16'hFFFF));
    it.ow   = ($urandom_range(0, 4) == 0);
    if (p < 55) begin
      it.cmd = CMD_INSERT;
      case ($urandom_range(0, 9))
        0: it.seq = $urandom;
        1: it.seq = next_seq + win + $urandom_range(0, 3);
        default: it.seq = next_seq + $urandom_range(0, win - 1);
      endcase
      if ($urandom_range(0, 11) == 0) it.blen = '0;
      else if ($urandom_range(0, 19) == 0) it.blen = '1;
    end else if (p < 70) begin
      it.cmd = CMD_DEQUEUE;
    end else if (p < 82) begin
      it.cmd = CMD_DRAIN;
    end else if (p < 92) begin
      it.cmd = CMD_FIND;
      if ($urandom_range(0, 5) != 0) it.seq = next_seq + $urandom_range(0, win + 2);
    end else if (p < 95) begin
      it.cmd = CMD_CLEAR;
    end else if (p < 97) begin
      it.cmd = CMD_RESTART;
    end else begin
      it.cmd = $urandom_range(0, 1) ? CMD_RSVD6 : CMD_RSVD7;
    end
    return it;
  endfunction

  function automatic void add_cmd(input logic [CMD_W-1:0] c, input logic [SEQ_W-1:0] s,
                                  input logic [REF_W-1:0] r, input logic [LEN_W-1:0] l,
                                  input logic w, input bit typed, input status_t st);
    stim_row_t row;
    row.is_cfg    = 1'b0;
    row.ws_val    = '0;
    row.start_val = '0;
    row.item.cmd  = c;
    row.item.seq  = s;
    row.item.bref = r;
    row.item.blen = l;
    row.item.ow   = w;
    row.typed     = typed;
    row.status    = st;
    stim_table.insert(stim_table.size(), row);
  endfunction

  function automatic void add_cfg(input logic [31:0] ws, input logic [31:0] start);
    stim_row_t row;
    row.is_cfg    = 1'b1;
    row.ws_val    = ws;
    row.start_val = start;
    row.item      = '{CMD_INSERT, '0, '0, '0, 1'b0};
    row.typed     = 1'b0;
    row.status    = ST_OK;
    stim_table.insert(stim_table.size(), row);
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s expected 0x%0h got 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  task automatic write_reg(input logic idx, input logic [PDATA_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (idx == REG_WINDOW_SIZE) cfg_window = value[WS_W-1:0];
    else cfg_start = value[START_W-1:0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    cmd_chan.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic issue_command(input window_cmd_t it, input bit typed, input status_t st);
    @(negedge clk);
    if (!calm && $urandom_range(0, 99) < 17) begin
      cmd_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    cmd_chan.valid        <= 1'b1;
    cmd_chan.cmd          <= it.cmd;
    cmd_chan.seq          <= it.seq;
    cmd_chan.block_ref    <= it.bref;
    cmd_chan.block_length <= it.blen;
    cmd_chan.overwrite    <= it.ow;
    @(posedge clk);
    while (!cmd_chan.ready) @(posedge clk);
    apply_window_cmd(it);
    if (typed) awaited_results[awaited_results.size()-1].status = st;
    if (it.cmd <= CMD_RESTART) cmds_sent++;
  endtask

  // result side: random back-pressure, one long hold on request
  initial begin
    result_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_out) begin
        hold_out = 1'b0;
        result_chan.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end else begin
        result_chan.ready <= calm || ($urandom_range(0, 99) >= 17);
      end
    end
  end

  always @(posedge clk) begin : result_check
    window_result_t want;
    if (rst_n && result_chan.valid && result_chan.ready) begin
      results_checked++;
      if (awaited_results.size() == 0) begin
        $error("unexpected result transaction, status %0d", result_chan.status);
        fail_count++;
      end else begin
        want = awaited_results.pop_front();
        check_field("status", want.status, result_chan.status);
        check_field("out_seq", want.rel_seq, result_chan.out_seq);
        check_field("out_ref", want.rel_ref, result_chan.out_ref);
        check_field("out_length", want.rel_len, result_chan.out_length);
        check_field("confirm_seq", want.confirm, result_chan.confirm_seq);
        check_field("max_seq", want.top, result_chan.max_seq);
        check_field("last", want.last, result_chan.last);
      end
    end
  end

  initial begin
    #3_000_000;
    $display("reorder_window_buffer_top verification failed");
    $finish;
  end

  initial begin
    window_cmd_t it;
    logic [31:0] ws_list [NUM_SETTINGS];
    logic [31:0] start_list [NUM_SETTINGS];
    int n, run_len;

    cmd_chan.valid        = 1'b0;
    cmd_chan.cmd          = CMD_INSERT;
    cmd_chan.seq          = '0;
    cmd_chan.block_ref    = '0;
    cmd_chan.block_length = '0;
    cmd_chan.overwrite    = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    rst_n   = 1'b0;
    calm     = 1'b0;
    hold_out = 1'b0;

    cfg_window = WS_RESET;
    cfg_start  = START_RESET;
    window_restart();

    add_cmd(CMD_FIND,    32'd0,          32'd0,          16'd0,      1'b0, 1, ST_NOT_FOUND);
    add_cmd(CMD_INSERT,  32'd0,          32'd1,          16'd0,      1'b0, 1, ST_BAD_LEN);
    add_cmd(CMD_INSERT,  32'd64,         32'd2,          16'd1,      1'b0, 1, ST_RANGE);
    add_cmd(CMD_INSERT,  32'hFFFF_FFFF,  32'd3,          16'd1,      1'b0, 1, ST_RANGE);
    add_cmd(CMD_INSERT,  32'd63,         32'hFFFF_FFFF,  16'hFFFF,   1'b0, 1, ST_FULL);
    add_cmd(CMD_INSERT,  32'd63,         32'd0,          16'd1,      1'b0, 1, ST_SLOT_USED);
    add_cmd(CMD_INSERT,  32'd63,         32'd0,          16'd1,      1'b1, 1, ST_FULL);
    add_cmd(CMD_INSERT,  32'd0,          32'h1234_5678,  16'd1,      1'b0, 1, ST_OK);
    add_cmd(CMD_FIND,    32'd0,          32'd0,          16'd0,      1'b0, 1, ST_FOUND);
    add_cmd(CMD_DEQUEUE, 32'd0,          32'd0,          16'd0,      1'b0, 0, ST_OK);
    add_cmd(CMD_DEQUEUE, 32'd0,          32'd0,          16'd0,      1'b0, 1, ST_EMPTY);
    add_cmd(CMD_INSERT,  32'd2,          32'hA5A5_0002,  16'h8000,   1'b0, 0, ST_OK);
    add_cmd(CMD_INSERT,  32'd1,          32'h5A5A_0001,  16'h7FFF,   1'b0, 0, ST_OK);
    add_cmd(CMD_DRAIN,   32'd0,          32'd0,          16'd0,      1'b0, 0, ST_OK);
    add_cmd(CMD_DRAIN,   32'd0,          32'd0,          16'd0,      1'b0, 1, ST_EMPTY);
    add_cmd(CMD_RSVD6,   32'd5,          32'd5,          16'd5,      1'b1, 0, ST_OK);
    add_cmd(CMD_RSVD7,   32'd6,          32'd6,          16'd6,      1'b0, 0, ST_OK);
    add_cmd(CMD_CLEAR,   32'd0,          32'd0,          16'd0,      1'b0, 1, ST_DONE);
    add_cmd(CMD_FIND,    32'd63,         32'd0,          16'd0,      1'b0, 1, ST_NOT_FOUND);
    add_cfg(32'd0, 32'h7FFF_FFFF);
    add_cmd(CMD_RESTART, 32'd0,          32'd0,          16'd0,      1'b0, 1, ST_DONE);
    add_cmd(CMD_INSERT,  32'h7FFF_FFFF,  32'hDEAD_BEEF,  16'd5,      1'b0, 1, ST_FULL);
    add_cmd(CMD_INSERT,  32'h8000_0000,  32'd7,          16'd5,      1'b0, 1, ST_RANGE);
    add_cmd(CMD_DRAIN,   32'd0,          32'd0,          16'd0,      1'b0, 0, ST_OK);
    add_cfg(32'd127, 32'h7FFF_FFFE);
    add_cmd(CMD_RESTART, 32'd0,          32'd0,          16'd0,      1'b0, 1, ST_DONE);
    add_cmd(CMD_INSERT,  32'h8000_0001,  32'd11,         16'd9,      1'b1, 0, ST_OK);
    add_cmd(CMD_INSERT,  32'h7FFF_FFFE,  32'd12,         16'd9,      1'b0, 0, ST_OK);
    add_cmd(CMD_INSERT,  32'h7FFF_FFFF,  32'd13,         16'd9,      1'b0, 0, ST_OK);
    add_cmd(CMD_INSERT,  32'h8000_0000,  32'd14,         16'd9,      1'b0, 0, ST_OK);
    add_cmd(CMD_DRAIN,   32'd0,          32'd0,          16'd0,      1'b0, 0, ST_OK);

    ws_list    = '{32'd64, 32'd1, 32'd0, 32'd127, 32'd5, 32'd64, 32'd2};
    start_list = '{32'd0, 32'h7FFF_FFFF, 32'h7FFF_FFF0, 32'h7FFF_FFC0,
                   $urandom, $urandom, 32'd0};

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (stim_table[i]) begin
      if (stim_table[i].is_cfg) begin
        wait_idle();
        write_reg(REG_WINDOW_SIZE, stim_table[i].ws_val);
        write_reg(REG_START_SEQ, stim_table[i].start_val);
      end else begin
        issue_command(stim_table[i].item, stim_table[i].typed, stim_table[i].status);
      end
    end

    for (int p = 0; p < NUM_SETTINGS; p++) begin
      wait_idle();
      write_reg(REG_WINDOW_SIZE, ws_list[p]);
      write_reg(REG_START_SEQ, start_list[p]);
      calm = (p == 3);
      it = '{CMD_RESTART, '0, '0, '0, 1'b0};
      issue_command(it, 1'b0, ST_OK);
      n = 0;
      while (n < PER_PHASE) begin
        if (p == 0 && n == 10) hold_out = 1'b1;
        if (p == 4 && n == 20) wait_idle();
        if ($urandom_range(0, 9) == 0) begin
          // fill a run top-down so the drain finds it contiguous
          run_len = $urandom_range(1, win);
          for (int j = run_len - 1; j >= 0; j--) begin
            it.cmd  = CMD_INSERT;
            it.seq  = next_seq + j;
            it.bref = $urandom;
            it.blen = LEN_W'($urandom_range(1, 16'hFFFF));
            it.ow   = 1'($urandom_range(0, 1));
            issue_command(it, 1'b0, ST_OK);
          end
          it.cmd = CMD_DRAIN;
          issue_command(it, 1'b0, ST_OK);
          n += run_len + 1;
        end else begin
          it = gen_item();
          issue_command(it, 1'b0, ST_OK);
          if (it.cmd <= CMD_RESTART) n++;
        end
      end
    end
    calm = 1'b0;

    @(negedge clk);
    cmd_chan.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Ran %0d commands over %0d window settings; %0d result transactions checked.",
             cmds_sent, NUM_SETTINGS + 3, results_checked);
    $display("Released %0d blocks in order; %0d inserts hit the top of the window.",
             blocks_released, full_hits);
    if (fail_count == 0) begin
      $display("reorder_window_buffer_top verification clean");
    end else begin
      $display("reorder_window_buffer_top verification failed");
    end
    $finish;
  end

endmodule

/* files.f */
design/rwb_pkg.sv
design/rwb_if.sv
design/rwb_cfg.sv
design/rwb_core.sv
design/reorder_window_buffer_top.sv
test/tb_reorder_window_buffer_top.sv
